>>> rtl/core/tstm_pkg.sv
// ----------------------------------------------------------------------------
// tstm_pkg
// shared types, codes and widths of the two-symbol turing machine core
// ----------------------------------------------------------------------------
package tstm_pkg;

   // default sizes
   localparam int TAPE_CELLS_DEF = 1024;
   localparam int MAX_STATES_DEF = 64;

   // field widths
   localparam int REQ_TYPE_W    = 3;
   localparam int INDEX_W       = 10;
   localparam int REPEAT_W      = 16;
   localparam int STATE_W       = 7;
   localparam int STATUS_W      = 2;
   localparam int STEP_TOTAL_W  = 32;
   localparam int COUNT_W       = 11;
   localparam int TAPE_LENGTH_W = 11;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 11;

   // register reset values
   localparam int TAPE_LENGTH_RESET = 1024;
   localparam int STATE_COUNT_RESET = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TAPE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUND_TAPE  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STATE_COUNT = 2'd2;

   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_STEP       = 3'd0,
      REQ_LOAD_RULE  = 3'd1,
      REQ_FLIP       = 3'd2,
      REQ_READ       = 3'd3,
      REQ_MOVE       = 3'd4,
      REQ_SET_STATE  = 3'd5,
      REQ_CLEAR      = 3'd6,
      REQ_ZERO_STEPS = 3'd7
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_HALTED    = 2'd1,
      STATUS_FAULT     = 2'd2,
      STATUS_BAD_INDEX = 2'd3
   } status_type;

   typedef struct packed {
      req_kind_type          req_type;
      logic [INDEX_W-1:0]    cell_or_rule_index;
      logic [REPEAT_W-1:0]   repeat_count;
      logic [STATE_W-1:0]    target_state;
      logic                  write_on_zero;
      logic                  write_on_one;
      logic                  right_on_zero;
      logic                  right_on_one;
      logic [STATE_W-1:0]    next_on_zero;
      logic [STATE_W-1:0]    next_on_one;
   } req_data_type;

   typedef struct packed {
      status_type                status;
      logic                      read_bit;
      logic [INDEX_W-1:0]        head_position;
      logic [STATE_W-1:0]        current_state;
      logic [STEP_TOTAL_W-1:0]   step_total;
      logic [REPEAT_W-1:0]       steps_taken;
      logic [COUNT_W-1:0]        ones_count;
      logic [COUNT_W-1:0]        zeros_count;
   } rsp_data_type;

   typedef struct packed {
      logic                  write_on_zero;
      logic                  write_on_one;
      logic                  right_on_zero;
      logic                  right_on_one;
      logic [STATE_W-1:0]    next_on_zero;
      logic [STATE_W-1:0]    next_on_one;
   } rule_type;

   localparam int RULE_W = $bits(rule_type);

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic init_wr;
      logic rc_issue;
      logic rc_done;
      logic apply;
      logic idx_rd;
      logic step_issue;
      logic step_exec;
      logic flip_wr;
      logic read_cap;
      logic clr_wr;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      req_kind_type req_type;
      logic         dirty;
      logic         bad_index;
      logic         step_stop;
      logic         sweep_last_full;
      logic         sweep_last_used;
      logic         out_busy;
   } dp_stat_type;

endpackage

>>> rtl/core/tstm_if.sv
// ----------------------------------------------------------------------------
// tstm_if
// request, response and register write channels
// ----------------------------------------------------------------------------
interface tstm_req_if;
   import tstm_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [REQ_TYPE_W-1:0]   req_type;
   logic [INDEX_W-1:0]      cell_or_rule_index;
   logic [REPEAT_W-1:0]     repeat_count;
   logic [STATE_W-1:0]      target_state;
   logic                    write_on_zero;
   logic                    write_on_one;
   logic                    right_on_zero;
   logic                    right_on_one;
   logic [STATE_W-1:0]      next_on_zero;
   logic [STATE_W-1:0]      next_on_one;

   modport source (
      output valid, req_type, cell_or_rule_index, repeat_count, target_state,
             write_on_zero, write_on_one, right_on_zero, right_on_one,
             next_on_zero, next_on_one,
      input  ready
   );
   modport sink (
      input  valid, req_type, cell_or_rule_index, repeat_count, target_state,
             write_on_zero, write_on_one, right_on_zero, right_on_one,
             next_on_zero, next_on_one,
      output ready
   );
endinterface

interface tstm_rsp_if;
   import tstm_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      read_bit;
   logic [INDEX_W-1:0]        head_position;
   logic [STATE_W-1:0]        current_state;
   logic [STEP_TOTAL_W-1:0]   step_total;
   logic [REPEAT_W-1:0]       steps_taken;
   logic [COUNT_W-1:0]        ones_count;
   logic [COUNT_W-1:0]        zeros_count;

   modport source (
      output valid, status, read_bit, head_position, current_state, step_total,
             steps_taken, ones_count, zeros_count,
      input  ready
   );
   modport sink (
      input  valid, status, read_bit, head_position, current_state, step_total,
             steps_taken, ones_count, zeros_count,
      output ready
   );
endinterface

interface tstm_csr_if;
   import tstm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_INDEX_W-1:0]   index;
   logic [CSR_DATA_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/tstm_ram.sv
// ----------------------------------------------------------------------------
// tstm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tstm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/tstm_dp.sv
// ----------------------------------------------------------------------------
// tstm_dp
// datapath: tape and rule memories, head, state, counters, registers
// ----------------------------------------------------------------------------
module tstm_dp #(
   parameter int TAPE_CELLS = tstm_pkg::TAPE_CELLS_DEF,
   parameter int MAX_STATES = tstm_pkg::MAX_STATES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tstm_pkg::dp_cmd_type                 cmd,
   output tstm_pkg::dp_stat_type                stat,
   input  tstm_pkg::req_data_type               req_data,
   input  logic                                 csr_write,
   input  logic [tstm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [tstm_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output tstm_pkg::rsp_data_type               rsp_data
);
   import tstm_pkg::*;

   localparam int AW  = $clog2(TAPE_CELLS);
   localparam int HW  = AW + 1;
   localparam int CW  = $clog2(TAPE_CELLS + 1);
   localparam int SAW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int LEN_RESET =
      (TAPE_CELLS < TAPE_LENGTH_RESET) ? TAPE_CELLS : TAPE_LENGTH_RESET;

   // registers
   logic [CW-1:0]            len_ff, len_in;
   logic                     round_ff, round_in;
   logic [STATE_W-1:0]       ns_ff, ns_in;
   logic                     dirty_ff, dirty_in;
   logic [CW-1:0]            sweep_ff, sweep_in;
   logic                     rc_pend_ff, rc_pend_in;
   logic [CW-1:0]            ones_ff, ones_in;
   logic [AW-1:0]            head_ff, head_in;
   logic [STATE_W-1:0]       state_ff, state_in;
   logic [STEP_TOTAL_W-1:0]  total_ff, total_in;
   logic                     fault_ff, fault_in;
   logic [REPEAT_W-1:0]      taken_ff, taken_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rbit_ff, rbit_in;
   req_data_type             req_ff, req_in;
   rsp_data_type             rsp_ff, rsp_in;

   // memory ports
   logic                     tape_we, tape_wdata, tape_bit;
   logic [AW-1:0]            tape_waddr, tape_raddr;
   logic                     rule_we;
   logic [SAW-1:0]           rule_waddr, rule_raddr;
   logic [RULE_W-1:0]        rule_rdata;
   rule_type                 rule_wr, rule;

   // step and decode helpers
   logic [31:0]              idx32, len32;
   logic [TAPE_LENGTH_W-1:0] tl_val;
   logic [STATE_W-1:0]       sc_val;
   logic                     bad, halted, head_used;
   logic                     wbit, right, off_right, off_left, move_off;
   logic [STATE_W-1:0]       nxt;
   logic [HW-1:0]            head_up;
   logic [AW-1:0]            head_step, len_last, idx_addr, sweep_addr;
   logic [CW-1:0]            ones_up, ones_dn;
   status_type               status_now;

   tstm_ram #(.WIDTH(1), .DEPTH(TAPE_CELLS)) u_tape (
      .clock (clock),
      .we    (tape_we),
      .waddr (tape_waddr),
      .wdata (tape_wdata),
      .raddr (tape_raddr),
      .rdata (tape_bit)
   );

   tstm_ram #(.WIDTH(RULE_W), .DEPTH(MAX_STATES)) u_rule (
      .clock (clock),
      .we    (rule_we),
      .waddr (rule_waddr),
      .wdata (rule_wr),
      .raddr (rule_raddr),
      .rdata (rule_rdata)
   );

   assign rule       = rule_type'(rule_rdata);
   assign idx32      = 32'(req_ff.cell_or_rule_index);
   assign len32      = 32'(len_ff);
   assign idx_addr   = AW'(req_ff.cell_or_rule_index);
   assign sweep_addr = sweep_ff[AW-1:0];
   assign halted     = (state_ff == '0) || (state_ff > ns_ff);
   assign head_used  = 32'(head_ff) < len32;
   assign ones_up    = ones_ff + CW'(1);
   assign ones_dn    = ones_ff - CW'(1);
   assign tl_val     = csr_data[TAPE_LENGTH_W-1:0];
   assign sc_val     = csr_data[STATE_W-1:0];

   // rule outcome for the bit under the head
   assign wbit      = tape_bit ? rule.write_on_one : rule.write_on_zero;
   assign right     = tape_bit ? rule.right_on_one : rule.right_on_zero;
   assign nxt       = tape_bit ? rule.next_on_one  : rule.next_on_zero;
   assign head_up   = {1'b0, head_ff} + HW'(1);
   assign off_right = 32'(head_up) >= len32;
   assign off_left  = (head_ff == '0) || (32'(head_ff) > len32);
   assign move_off  = right ? off_right : off_left;
   assign len_last  = AW'(len_ff - CW'(1));
   assign head_step = right ? (off_right ? '0 : head_up[AW-1:0])
                            : (off_left ? len_last : head_ff - AW'(1));

   always_comb begin
      unique case (req_ff.req_type) inside
         REQ_LOAD_RULE: bad = (idx32 >= 32'(ns_ff)) ||
                              (req_ff.next_on_zero > ns_ff) ||
                              (req_ff.next_on_one > ns_ff);
         REQ_FLIP, REQ_READ, REQ_MOVE: bad = idx32 >= len32;
         REQ_SET_STATE: bad = req_ff.target_state > ns_ff;
         default: bad = 1'b0;
      endcase
   end

   always_comb begin
      if (bad) begin
         status_now = STATUS_BAD_INDEX;
      end else if (fault_ff) begin
         status_now = STATUS_FAULT;
      end else if (halted) begin
         status_now = STATUS_HALTED;
      end else begin
         status_now = STATUS_OK;
      end
   end

   always_comb begin
      len_in       = len_ff;
      round_in     = round_ff;
      ns_in        = ns_ff;
      dirty_in     = dirty_ff;
      sweep_in     = sweep_ff;
      rc_pend_in   = cmd.rc_issue;
      ones_in      = ones_ff;
      head_in      = head_ff;
      state_in     = state_ff;
      total_in     = total_ff;
      fault_in     = fault_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff;
      rbit_in      = rbit_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;

      tape_we    = 1'b0;
      tape_waddr = sweep_addr;
      tape_wdata = 1'b0;
      tape_raddr = head_ff;
      rule_we    = 1'b0;
      rule_waddr = SAW'(req_ff.cell_or_rule_index);
      rule_raddr = SAW'(state_ff - STATE_W'(1));
      rule_wr    = '{
         write_on_zero: req_ff.write_on_zero,
         write_on_one:  req_ff.write_on_one,
         right_on_zero: req_ff.right_on_zero,
         right_on_one:  req_ff.right_on_one,
         next_on_zero:  req_ff.next_on_zero,
         next_on_one:   req_ff.next_on_one
      };

      // register writes; used length clamped to 1..TAPE_CELLS
      if (csr_write) begin
         unique case (csr_index)
            CSR_TAPE_LENGTH: begin
               if (tl_val == '0) begin
                  len_in = CW'(1);
               end else if (32'(tl_val) > 32'(TAPE_CELLS)) begin
                  len_in = CW'(TAPE_CELLS);
               end else begin
                  len_in = CW'(tl_val);
               end
               dirty_in = 1'b1;
            end
            CSR_ROUND_TAPE: round_in = csr_data[0];
            CSR_STATE_COUNT: begin
               if (sc_val == '0) begin
                  ns_in = STATE_W'(1);
               end else if (32'(sc_val) > 32'(MAX_STATES)) begin
                  ns_in = STATE_W'(MAX_STATES);
               end else begin
                  ns_in = sc_val;
               end
            end
            default: ;
         endcase
      end

      // recount accumulates the read bit in the cycle after its read is issued
      if (rc_pend_ff && tape_bit) begin
         ones_in = ones_up;
      end

      if (cmd.accept) begin
         req_in   = req_data;
         sweep_in = '0;
         taken_in = '0;
         rbit_in  = 1'b0;
         if (dirty_ff) begin
            ones_in = '0;
         end
      end

      if (cmd.init_wr || cmd.clr_wr) begin
         tape_we  = 1'b1;
         sweep_in = sweep_ff + CW'(1);
      end

      if (cmd.clr_wr) begin
         ones_in  = '0;
         dirty_in = 1'b0;
      end

      if (cmd.rc_issue) begin
         tape_raddr = sweep_addr;
         sweep_in   = sweep_ff + CW'(1);
      end

      if (cmd.rc_done) begin
         dirty_in = 1'b0;
         sweep_in = '0;
      end

      if (cmd.apply && !bad) begin
         unique case (req_ff.req_type)
            REQ_LOAD_RULE:  rule_we  = 1'b1;
            REQ_MOVE:       head_in  = idx_addr;
            REQ_SET_STATE:  state_in = req_ff.target_state;
            REQ_ZERO_STEPS: total_in = '0;
            default: ;
         endcase
      end

      if (cmd.idx_rd) begin
         tape_raddr = idx_addr;
      end

      if (cmd.step_exec) begin
         tape_we    = 1'b1;
         tape_waddr = head_ff;
         tape_wdata = wbit;
         if (head_used && (wbit != tape_bit)) begin
            ones_in = wbit ? ones_up : ones_dn;
         end
         if (move_off && !round_ff) begin
            fault_in = 1'b1;
         end else begin
            head_in  = head_step;
            state_in = nxt;
            taken_in = taken_ff + REPEAT_W'(1);
            if (total_ff != '1) begin
               total_in = total_ff + STEP_TOTAL_W'(1);
            end
         end
      end

      if (cmd.flip_wr) begin
         tape_we    = 1'b1;
         tape_waddr = idx_addr;
         tape_wdata = !tape_bit;
         ones_in    = tape_bit ? ones_dn : ones_up;
      end

      if (cmd.read_cap) begin
         rbit_in = tape_bit;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.finish) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = status_now;
         rsp_in.read_bit      = rbit_ff;
         rsp_in.head_position = INDEX_W'(head_ff);
         rsp_in.current_state = state_ff;
         rsp_in.step_total    = total_ff;
         rsp_in.steps_taken   = taken_ff;
         rsp_in.ones_count    = COUNT_W'(ones_ff);
         rsp_in.zeros_count   = COUNT_W'(len_ff - ones_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= CW'(LEN_RESET);
         round_ff     <= 1'b0;
         ns_ff        <= STATE_W'(STATE_COUNT_RESET);
         dirty_ff     <= 1'b0;
         sweep_ff     <= '0;
         rc_pend_ff   <= 1'b0;
         ones_ff      <= '0;
         head_ff      <= '0;
         state_ff     <= STATE_W'(1);
         total_ff     <= '0;
         fault_ff     <= 1'b0;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         round_ff     <= round_in;
         ns_ff        <= ns_in;
         dirty_ff     <= dirty_in;
         sweep_ff     <= sweep_in;
         rc_pend_ff   <= rc_pend_in;
         ones_ff      <= ones_in;
         head_ff      <= head_in;
         state_ff     <= state_in;
         total_ff     <= total_in;
         fault_ff     <= fault_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rbit_ff <= rbit_in;
      req_ff  <= req_in;
      rsp_ff  <= rsp_in;
   end

   assign stat.req_type        = req_ff.req_type;
   assign stat.dirty           = dirty_ff;
   assign stat.bad_index       = bad;
   assign stat.step_stop       = fault_ff || halted || (taken_ff == req_ff.repeat_count);
   assign stat.sweep_last_full = sweep_ff == CW'(TAPE_CELLS - 1);
   assign stat.sweep_last_used = sweep_ff == (len_ff - CW'(1));
   assign stat.out_busy        = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      fault_ff |=> fault_ff)
      else $error("fault flag cleared without reset");

   a_step_budget: assert property (@(posedge clock) disable iff (reset)
      cmd.step_exec |-> (taken_ff < req_ff.repeat_count))
      else $error("step executed beyond repeat count");

   a_ones_bound: assert property (@(posedge clock) disable iff (reset)
      !dirty_ff |-> (32'(ones_ff) <= len32))
      else $error("ones count exceeds used tape length");
`endif

endmodule

>>> rtl/core/tstm_ctrl.sv
// ----------------------------------------------------------------------------
// tstm_ctrl
// request sequencer: clearing pass, recount, dispatch and step loop
// ----------------------------------------------------------------------------
module tstm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output tstm_pkg::dp_cmd_type   cmd,
   input  tstm_pkg::dp_stat_type  stat
);
   import tstm_pkg::*;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_RC_RUN,
      ST_RC_TAIL,
      ST_DISPATCH,
      ST_STEP_CHK,
      ST_STEP_EXEC,
      ST_FLIP_WR,
      ST_READ_CAP,
      ST_CLR_RUN,
      ST_FINISH
   } fsm_state_type;

   fsm_state_type state_ff, state_in;
   logic          ready_ff, ready_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (stat.sweep_last_full) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.accept = 1'b1;
               state_in   = stat.dirty ? ST_RC_RUN : ST_DISPATCH;
            end
         end
         ST_RC_RUN: begin
            cmd.rc_issue = 1'b1;
            if (stat.sweep_last_used) begin
               state_in = ST_RC_TAIL;
            end
         end
         ST_RC_TAIL: begin
            cmd.rc_done = 1'b1;
            state_in    = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            unique case (stat.req_type) inside
               REQ_STEP: state_in = ST_STEP_CHK;
               REQ_FLIP, REQ_READ: begin
                  if (stat.bad_index) begin
                     state_in = ST_FINISH;
                  end else begin
                     cmd.idx_rd = 1'b1;
                     state_in   = (stat.req_type == REQ_FLIP) ? ST_FLIP_WR : ST_READ_CAP;
                  end
               end
               REQ_CLEAR: state_in = ST_CLR_RUN;
               default: begin
                  cmd.apply = 1'b1;
                  state_in  = ST_FINISH;
               end
            endcase
         end
         ST_STEP_CHK: begin
            if (stat.step_stop) begin
               state_in = ST_FINISH;
            end else begin
               cmd.step_issue = 1'b1;
               state_in       = ST_STEP_EXEC;
            end
         end
         ST_STEP_EXEC: begin
            cmd.step_exec = 1'b1;
            state_in      = ST_STEP_CHK;
         end
         ST_FLIP_WR: begin
            cmd.flip_wr = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_READ_CAP: begin
            cmd.read_cap = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_CLR_RUN: begin
            cmd.clr_wr = 1'b1;
            if (stat.sweep_last_used) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = state_in == ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

`ifndef SYNTHESIS
   a_issue_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.step_issue |=> cmd.step_exec)
      else $error("rule read not followed by step execution");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one in progress");
`endif

endmodule

>>> rtl/core/two_symbol_turing_machine_core.sv
// ----------------------------------------------------------------------------
// two_symbol_turing_machine_core: two-symbol turing machine engine, one response per request
// sequence: clear tape sweeps the used length; a step request runs a check and an execute
//   state per step, a step that falls off the tape included; the first request after a
//   tape_length write starts with a recount over the used length
// throughput: one request at a time; a step costs one rule/tape read and one tape write
// reset: synchronous; a clearing pass over all TAPE_CELLS cells zeroes the tape first
// ----------------------------------------------------------------------------
module two_symbol_turing_machine_core #(
   parameter int TAPE_CELLS = tstm_pkg::TAPE_CELLS_DEF,
   parameter int MAX_STATES = tstm_pkg::MAX_STATES_DEF
) (
   input logic        clock,
   input logic        reset,
   tstm_req_if.sink   req_if,
   tstm_rsp_if.source rsp_if,
   tstm_csr_if.sink   csr_if
);
   import tstm_pkg::*;

   // request payload gathered into one word for the datapath
   req_data_type req_data;
   rsp_data_type rsp_data;
   dp_cmd_type   cmd;
   dp_stat_type  stat;
   logic         rsp_valid;
   logic         csr_write;

   assign req_data.req_type           = req_kind_type'(req_if.req_type);
   assign req_data.cell_or_rule_index = req_if.cell_or_rule_index;
   assign req_data.repeat_count       = req_if.repeat_count;
   assign req_data.target_state       = req_if.target_state;
   assign req_data.write_on_zero      = req_if.write_on_zero;
   assign req_data.write_on_one       = req_if.write_on_one;
   assign req_data.right_on_zero      = req_if.right_on_zero;
   assign req_data.right_on_one       = req_if.right_on_one;
   assign req_data.next_on_zero       = req_if.next_on_zero;
   assign req_data.next_on_one        = req_if.next_on_one;

   // registers are always writable; the sender must write them only while idle, the core does not enforce it
   assign csr_if.ready = 1'b1;
   assign csr_write    = csr_if.valid && csr_if.ready;

   // controller: owns request ready and sequences every request
   tstm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // datapath: tape, rule table, machine registers and response register
   tstm_dp #(
      .TAPE_CELLS (TAPE_CELLS),
      .MAX_STATES (MAX_STATES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_if.index),
      .csr_data  (csr_if.data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_if.ready),
      .rsp_data  (rsp_data)
   );

   // response register drives the result channel directly
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.status        = rsp_data.status;
   assign rsp_if.read_bit      = rsp_data.read_bit;
   assign rsp_if.head_position = rsp_data.head_position;
   assign rsp_if.current_state = rsp_data.current_state;
   assign rsp_if.step_total    = rsp_data.step_total;
   assign rsp_if.steps_taken   = rsp_data.steps_taken;
   assign rsp_if.ones_count    = rsp_data.ones_count;
   assign rsp_if.zeros_count   = rsp_data.zeros_count;

endmodule
